// ----- sv/calendar_cron_minute_matcher_defines.svh -----
`ifndef CALENDAR_CRON_MINUTE_MATCHER_DEFINES_SVH
`define CALENDAR_CRON_MINUTE_MATCHER_DEFINES_SVH

// same-cycle implication, reset masks the check
`define CCM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CCM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/ccm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ccm_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int WDAY_W   = 3;

    localparam int MIN_MASK_W  = 60;
    localparam int HOUR_MASK_W = 24;
    localparam int DAY_MASK_W  = 31;
    localparam int MON_MASK_W  = 12;
    localparam int WDAY_MASK_W = 7;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = MIN_MASK_W;

    localparam logic [YEAR_W-1:0]   YEAR_MAX   = 14'd9999;
    localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [DAY_W-1:0]    DAY_MAX    = 5'd31;

    localparam logic [YEAR_W-1:0]   RST_YEAR   = 14'd1970;
    localparam logic [MONTH_W-1:0]  RST_MONTH  = 4'd1;
    localparam logic [DAY_W-1:0]    RST_DAY    = 5'd1;
    localparam logic [HOUR_W-1:0]   RST_HOUR   = 5'd0;
    localparam logic [MINUTE_W-1:0] RST_MINUTE = 6'd0;

    // 2^19 / 100, rounded up; exact quotient for any 14-bit year
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MINUTE  = 3'd0,
        CFG_HOUR    = 3'd1,
        CFG_DAY     = 3'd2,
        CFG_MONTH   = 3'd3,
        CFG_WEEKDAY = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    function automatic logic f_is_leap(input logic [YEAR_W-1:0] y);
        logic [26:0] p;
        logic        div100;
        begin
            p = 27'(y) * 27'(RECIP_100);
            // fraction below one step of the reciprocal means remainder zero
            div100 = (p[RECIP_SH-1:0] < 19'(RECIP_100));
            return (y[1:0] == 2'd0) && (!div100 || (p[RECIP_SH+1:RECIP_SH] == 2'd0));
        end
    endfunction

    function automatic logic [DAY_W-1:0] f_days_in(input logic [YEAR_W-1:0] y,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] d;
        begin
            if (m == 4'd2) begin
                d = f_is_leap(y) ? 5'd29 : 5'd28;
            end else if (m inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
                d = 5'd30;
            end else begin
                d = DAY_MAX;
            end
            return d;
        end
    endfunction

    // month term of the congruence plus the Sunday rebase, mod 7
    function automatic logic [WDAY_W-1:0] f_month_offset(input logic [MONTH_W-1:0] m);
        logic [WDAY_W-1:0] o;
        begin
            case (m)
                4'd1:    o = 3'd0;
                4'd2:    o = 3'd3;
                4'd3:    o = 3'd2;
                4'd4:    o = 3'd5;
                4'd5:    o = 3'd0;
                4'd6:    o = 3'd3;
                4'd7:    o = 3'd5;
                4'd8:    o = 3'd1;
                4'd9:    o = 3'd4;
                4'd10:   o = 3'd6;
                4'd11:   o = 3'd2;
                4'd12:   o = 3'd4;
                default: o = 3'd0;
            endcase
            return o;
        end
    endfunction

endpackage

`default_nettype wire

// ----- sv/ccm_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ccm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ccm_pkg::CFG_IDX_W-1:0]  index;
    logic [ccm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/ccm_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ccm_in_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [ccm_pkg::YEAR_W-1:0]   year;
    logic [ccm_pkg::MONTH_W-1:0]  month;
    logic [ccm_pkg::DAY_W-1:0]    day;
    logic [ccm_pkg::HOUR_W-1:0]   hour;
    logic [ccm_pkg::MINUTE_W-1:0] minute;

    modport source (output valid, output kind, output year, output month, output day,
                    output hour, output minute, input ready);
    modport sink   (input valid, input kind, input year, input month, input day,
                    input hour, input minute, output ready);
endinterface

`default_nettype wire

// ----- sv/ccm_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ccm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         matched;
    logic [ccm_pkg::YEAR_W-1:0]   out_year;
    logic [ccm_pkg::MONTH_W-1:0]  out_month;
    logic [ccm_pkg::DAY_W-1:0]    out_day;
    logic [ccm_pkg::HOUR_W-1:0]   out_hour;
    logic [ccm_pkg::MINUTE_W-1:0] out_minute;
    logic [ccm_pkg::WDAY_W-1:0]   out_weekday;

    modport source (output valid, output matched, output out_year, output out_month,
                    output out_day, output out_hour, output out_minute,
                    output out_weekday, input ready);
    modport sink   (input valid, input matched, input out_year, input out_month,
                    input out_day, input out_hour, input out_minute,
                    input out_weekday, output ready);
endinterface

`default_nettype wire

// ----- sv/ccm_weekday.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Gregorian weekday, 0 is Sunday; date must be in range
module ccm_weekday (
    input  ccm_pkg::t_date              i_date,
    output logic [ccm_pkg::WDAY_W-1:0]  o_weekday
);
    import ccm_pkg::*;

    logic [YEAR_W-1:0] ya;
    logic [26:0]       prod;
    logic [7:0]        cent;
    logic [14:0]       sum;
    logic [5:0]        fold1;
    logic [3:0]        fold2;

    // Jan and Feb count as months of the previous year
    assign ya   = (i_date.month < 4'd3) ? (i_date.year - 14'd1) : i_date.year;
    assign prod = 27'(ya) * 27'(RECIP_100);
    assign cent = prod[26:RECIP_SH];

    // y + y/4 - y/100 + y/400 + day + month term
    assign sum = 15'(ya) + 15'(ya >> 2) - 15'(cent) + 15'(cent >> 2)
               + 15'(i_date.day) + 15'(f_month_offset(i_date.month));

    // 8 = 1 mod 7: add octal digits
    assign fold1 = 6'(sum[2:0]) + 6'(sum[5:3]) + 6'(sum[8:6]) + 6'(sum[11:9])
                 + 6'(sum[14:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[5:3]);
    assign o_weekday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

endmodule

`default_nettype wire

// ----- sv/calendar_cron_minute_matcher.sv -----
// channel  dir  handshake        word
// i_cfg    in   valid / ready    index, data (mask write)
// i_in     in   valid / ready    kind, year, month, day, hour, minute
// o_out    out  valid / ready    matched, out_year .. out_minute, out_weekday
//
// One item per cycle sustained while o_out is ready. An item is held in the
// input register, then its result is computed and loaded into the output
// register together with the calendar update. Input and output registers
// decouple the sides: one item is taken while a result waits. i_cfg is
// always ready. Synchronous active-low reset sets 1970-01-01 00:00 and all
// masks to all ones.
`timescale 1ns / 1ps
`default_nettype none

module calendar_cron_minute_matcher (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccm_cfg_if.sink   i_cfg,
    ccm_in_if.sink    i_in,
    ccm_out_if.source o_out
);
    import ccm_pkg::*;

`include "calendar_cron_minute_matcher_defines.svh"

    logic [MIN_MASK_W-1:0]  r_minute_mask;
    logic [HOUR_MASK_W-1:0] r_hour_mask;
    logic [DAY_MASK_W-1:0]  r_day_mask;
    logic [MON_MASK_W-1:0]  r_month_mask;
    logic [WDAY_MASK_W-1:0] r_weekday_mask;

    logic [YEAR_W-1:0]   r_cur_year,   n_cur_year;
    logic [MONTH_W-1:0]  r_cur_month,  n_cur_month;
    logic [DAY_W-1:0]    r_cur_day,    n_cur_day;
    logic [HOUR_W-1:0]   r_cur_hour,   n_cur_hour;
    logic [MINUTE_W-1:0] r_cur_minute, n_cur_minute;

    logic                r_a_valid;
    logic                r_a_kind;
    logic [YEAR_W-1:0]   r_a_year;
    logic [MONTH_W-1:0]  r_a_month;
    logic [DAY_W-1:0]    r_a_day;
    logic [HOUR_W-1:0]   r_a_hour;
    logic [MINUTE_W-1:0] r_a_minute;

    logic                r_b_valid;
    logic                r_b_matched;
    logic [YEAR_W-1:0]   r_b_year;
    logic [MONTH_W-1:0]  r_b_month;
    logic [DAY_W-1:0]    r_b_day;
    logic [HOUR_W-1:0]   r_b_hour;
    logic [MINUTE_W-1:0] r_b_minute;
    logic [WDAY_W-1:0]   r_b_wday;

    logic                in_acc;
    logic                a_move;
    logic                is_tick;

    logic [YEAR_W-1:0]   ld_year;
    logic [MONTH_W-1:0]  ld_month;
    logic [DAY_W-1:0]    ld_dim;
    logic [DAY_W-1:0]    ld_day;
    logic [HOUR_W-1:0]   ld_hour;
    logic [MINUTE_W-1:0] ld_minute;

    logic [DAY_W-1:0]    cur_dim;
    logic                at_end;
    logic [YEAR_W-1:0]   tk_year;
    logic [MONTH_W-1:0]  tk_month;
    logic [DAY_W-1:0]    tk_day;
    logic [HOUR_W-1:0]   tk_hour;
    logic [MINUTE_W-1:0] tk_minute;

    t_date               sel_date;
    logic [HOUR_W-1:0]   sel_hour;
    logic [MINUTE_W-1:0] sel_minute;
    logic [WDAY_W-1:0]   sel_wday;
    logic [DAY_W-1:0]    day_idx;
    logic [MONTH_W-1:0]  mon_idx;
    logic                hit;

    // handshakes
    assign i_cfg.ready = 1'b1;
    assign a_move      = r_a_valid && (!r_b_valid || o_out.ready);
    assign i_in.ready  = !r_a_valid || a_move;
    assign in_acc      = i_in.valid && i_in.ready;
    assign is_tick     = (r_a_kind == KIND_TICK);

    // load clamping
    always_comb begin
        if (r_a_year == '0) begin
            ld_year = 14'd1;
        end else if (r_a_year > YEAR_MAX) begin
            ld_year = YEAR_MAX;
        end else begin
            ld_year = r_a_year;
        end
        if (r_a_month == '0) begin
            ld_month = 4'd1;
        end else if (r_a_month > MONTH_MAX) begin
            ld_month = MONTH_MAX;
        end else begin
            ld_month = r_a_month;
        end
        ld_dim = f_days_in(ld_year, ld_month);
        if (r_a_day == '0) begin
            ld_day = 5'd1;
        end else if (r_a_day > ld_dim) begin
            ld_day = ld_dim;
        end else begin
            ld_day = r_a_day;
        end
        ld_hour   = (r_a_hour > HOUR_MAX) ? HOUR_MAX : r_a_hour;
        ld_minute = (r_a_minute > MINUTE_MAX) ? MINUTE_MAX : r_a_minute;
    end

    // one-minute advance, held at the last minute of year 9999
    assign cur_dim = f_days_in(r_cur_year, r_cur_month);
    assign at_end  = (r_cur_year >= YEAR_MAX) && (r_cur_month == MONTH_MAX)
                   && (r_cur_day == DAY_MAX) && (r_cur_hour == HOUR_MAX)
                   && (r_cur_minute == MINUTE_MAX);

    always_comb begin
        tk_year   = r_cur_year;
        tk_month  = r_cur_month;
        tk_day    = r_cur_day;
        tk_hour   = r_cur_hour;
        tk_minute = r_cur_minute;
        if (!at_end) begin
            if (r_cur_minute == MINUTE_MAX) begin
                tk_minute = '0;
                if (r_cur_hour == HOUR_MAX) begin
                    tk_hour = '0;
                    if (r_cur_day == cur_dim) begin
                        tk_day = 5'd1;
                        if (r_cur_month == MONTH_MAX) begin
                            tk_month = 4'd1;
                            tk_year  = r_cur_year + 14'd1;
                        end else begin
                            tk_month = r_cur_month + 4'd1;
                        end
                    end else begin
                        tk_day = r_cur_day + 5'd1;
                    end
                end else begin
                    tk_hour = r_cur_hour + 5'd1;
                end
            end else begin
                tk_minute = r_cur_minute + 6'd1;
            end
        end
    end

    // reported minute: loaded value for a load, current value for a tick
    always_comb begin
        if (is_tick) begin
            sel_date.year  = r_cur_year;
            sel_date.month = r_cur_month;
            sel_date.day   = r_cur_day;
            sel_hour       = r_cur_hour;
            sel_minute     = r_cur_minute;
        end else begin
            sel_date.year  = ld_year;
            sel_date.month = ld_month;
            sel_date.day   = ld_day;
            sel_hour       = ld_hour;
            sel_minute     = ld_minute;
        end
    end

    ccm_weekday u_weekday (
        .i_date    (sel_date),
        .o_weekday (sel_wday)
    );

    assign day_idx = sel_date.day - 5'd1;
    assign mon_idx = sel_date.month - 4'd1;
    assign hit = is_tick && r_minute_mask[sel_minute] && r_hour_mask[sel_hour]
               && r_day_mask[day_idx] && r_month_mask[mon_idx] && r_weekday_mask[sel_wday];

    always_comb begin
        n_cur_year   = r_cur_year;
        n_cur_month  = r_cur_month;
        n_cur_day    = r_cur_day;
        n_cur_hour   = r_cur_hour;
        n_cur_minute = r_cur_minute;
        if (a_move) begin
            if (is_tick) begin
                n_cur_year   = tk_year;
                n_cur_month  = tk_month;
                n_cur_day    = tk_day;
                n_cur_hour   = tk_hour;
                n_cur_minute = tk_minute;
            end else begin
                n_cur_year   = ld_year;
                n_cur_month  = ld_month;
                n_cur_day    = ld_day;
                n_cur_hour   = ld_hour;
                n_cur_minute = ld_minute;
            end
        end
    end

    // mask registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_minute_mask  <= '1;
            r_hour_mask    <= '1;
            r_day_mask     <= '1;
            r_month_mask   <= '1;
            r_weekday_mask <= '1;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_MINUTE:  r_minute_mask  <= i_cfg.data[MIN_MASK_W-1:0];
                CFG_HOUR:    r_hour_mask    <= i_cfg.data[HOUR_MASK_W-1:0];
                CFG_DAY:     r_day_mask     <= i_cfg.data[DAY_MASK_W-1:0];
                CFG_MONTH:   r_month_mask   <= i_cfg.data[MON_MASK_W-1:0];
                CFG_WEEKDAY: r_weekday_mask <= i_cfg.data[WDAY_MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // calendar state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_year   <= RST_YEAR;
            r_cur_month  <= RST_MONTH;
            r_cur_day    <= RST_DAY;
            r_cur_hour   <= RST_HOUR;
            r_cur_minute <= RST_MINUTE;
        end else begin
            r_cur_year   <= n_cur_year;
            r_cur_month  <= n_cur_month;
            r_cur_day    <= n_cur_day;
            r_cur_hour   <= n_cur_hour;
            r_cur_minute <= n_cur_minute;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_acc) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_kind   <= i_in.kind;
            r_a_year   <= i_in.year;
            r_a_month  <= i_in.month;
            r_a_day    <= i_in.day;
            r_a_hour   <= i_in.hour;
            r_a_minute <= i_in.minute;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_matched <= hit;
            r_b_year    <= sel_date.year;
            r_b_month   <= sel_date.month;
            r_b_day     <= sel_date.day;
            r_b_hour    <= sel_hour;
            r_b_minute  <= sel_minute;
            r_b_wday    <= sel_wday;
        end
    end

    assign o_out.valid       = r_b_valid;
    assign o_out.matched     = r_b_matched;
    assign o_out.out_year    = r_b_year;
    assign o_out.out_month   = r_b_month;
    assign o_out.out_day     = r_b_day;
    assign o_out.out_hour    = r_b_hour;
    assign o_out.out_minute  = r_b_minute;
    assign o_out.out_weekday = r_b_wday;

    `CCM_ASSERT_IMP(a_day_fits, i_clk, i_rst_n, 1'b1,
        (r_cur_day >= 5'd1) && (r_cur_day <= f_days_in(r_cur_year, r_cur_month)),
        "calendar day outside its month")
    `CCM_ASSERT_NXT(a_load_nomatch, i_clk, i_rst_n, a_move && (r_a_kind == KIND_LOAD),
        !r_b_matched, "load word reported a match")
    `CCM_ASSERT_NXT(a_end_hold, i_clk, i_rst_n, a_move && is_tick && at_end,
        $stable(r_cur_year) && $stable(r_cur_month) && $stable(r_cur_day)
        && $stable(r_cur_hour) && $stable(r_cur_minute),
        "calendar moved past its last minute")
    `CCM_ASSERT_IMP(a_out_range, i_clk, i_rst_n, r_b_valid,
        (r_b_month >= 4'd1) && (r_b_month <= MONTH_MAX) && (r_b_day >= 5'd1)
        && (r_b_hour <= HOUR_MAX) && (r_b_minute <= MINUTE_MAX) && (r_b_wday <= 3'd6),
        "result word out of range")

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import ccm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 8;
    localparam int BLOCK_WORDS = 95;

    typedef struct packed {
        t_kind                kind;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
    } t_minute_cmd;

    typedef struct packed {
        logic                 matched;
        logic [YEAR_W-1:0]    year;
        logic [MONTH_W-1:0]   month;
        logic [DAY_W-1:0]     day;
        logic [HOUR_W-1:0]    hour;
        logic [MINUTE_W-1:0]  minute;
        logic [WDAY_W-1:0]    weekday;
    } t_minute_report;

    logic i_clk;
    logic i_rst_n;

    ccm_cfg_if cfg_bus ();
    ccm_in_if  in_bus ();
    ccm_out_if out_bus ();

    calendar_cron_minute_matcher u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // predicted calendar and schedule masks
    int                     cal_year, cal_month, cal_day, cal_hour, cal_minute;
    logic [MIN_MASK_W-1:0]  minute_allow;
    logic [HOUR_MASK_W-1:0] hour_allow;
    logic [DAY_MASK_W-1:0]  day_allow;
    logic [MON_MASK_W-1:0]  month_allow;
    logic [WDAY_MASK_W-1:0] weekday_allow;

    t_minute_report pending_reports[$];
    int             mismatches;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit is_leap_year(int y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    function automatic int month_days(int y, int m);
        case (m)
            2:          return is_leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    // Zeller, shifted so that Sunday is 0
    function automatic int weekday_of_date(int y, int m, int d);
        int j, k, h;
        if (m < 3) begin
            m += 12;
            y -= 1;
        end
        j = y / 100;
        k = y % 100;
        h = (d + (13 * (m + 1)) / 5 + k + k / 4 + j / 4 + 5 * j) % 7;
        return (h + 6) % 7;
    endfunction

    function automatic void reset_calendar();
        cal_year      = 1970;
        cal_month     = 1;
        cal_day       = 1;
        cal_hour      = 0;
        cal_minute    = 0;
        minute_allow  = '1;
        hour_allow    = '1;
        day_allow     = '1;
        month_allow   = '1;
        weekday_allow = '1;
    endfunction

    function automatic void apply_mask_write(logic [CFG_IDX_W-1:0] idx,
                                             logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_MINUTE:  minute_allow  = data[MIN_MASK_W-1:0];
            CFG_HOUR:    hour_allow    = data[HOUR_MASK_W-1:0];
            CFG_DAY:     day_allow     = data[DAY_MASK_W-1:0];
            CFG_MONTH:   month_allow   = data[MON_MASK_W-1:0];
            CFG_WEEKDAY: weekday_allow = data[WDAY_MASK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic t_minute_report report_minute(t_minute_cmd c);
        t_minute_report r;
        int             wd, dl;
        bit             at_end;
        r.matched = 1'b0;
        if (c.kind == KIND_LOAD) begin
            cal_year   = (c.year < 1) ? 1 : ((c.year > YEAR_MAX) ? YEAR_MAX : c.year);
            cal_month  = (c.month < 1) ? 1 : ((c.month > MONTH_MAX) ? MONTH_MAX : c.month);
            dl         = month_days(cal_year, cal_month);
            cal_day    = (c.day < 1) ? 1 : ((c.day > dl) ? dl : c.day);
            cal_hour   = (c.hour > HOUR_MAX) ? HOUR_MAX : c.hour;
            cal_minute = (c.minute > MINUTE_MAX) ? MINUTE_MAX : c.minute;
        end
        wd = weekday_of_date(cal_year, cal_month, cal_day);
        if (c.kind == KIND_TICK) begin
            r.matched = minute_allow[cal_minute] && hour_allow[cal_hour] &&
                        day_allow[cal_day - 1] && month_allow[cal_month - 1] &&
                        weekday_allow[wd];
        end
        r.year    = YEAR_W'(cal_year);
        r.month   = MONTH_W'(cal_month);
        r.day     = DAY_W'(cal_day);
        r.hour    = HOUR_W'(cal_hour);
        r.minute  = MINUTE_W'(cal_minute);
        r.weekday = WDAY_W'(wd);
        if (c.kind == KIND_TICK) begin
            at_end = cal_year >= YEAR_MAX && cal_month == 12 && cal_day == 31 &&
                     cal_hour == 23 && cal_minute == 59;
            if (!at_end) begin
                cal_minute++;
                if (cal_minute >= 60) begin
                    cal_minute = 0;
                    cal_hour++;
                    if (cal_hour >= 24) begin
                        cal_hour = 0;
                        cal_day++;
                        if (cal_day > month_days(cal_year, cal_month)) begin
                            cal_day = 1;
                            cal_month++;
                            if (cal_month > 12) begin
                                cal_month = 1;
                                cal_year++;
                            end
                        end
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic void check_field(string name, int unsigned exp_val,
                                        int unsigned act_val);
        if (exp_val != act_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_minute_report exp_rep;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            if (pending_reports.size() == 0) begin
                $error("result word with nothing pending");
                mismatches++;
            end else begin
                exp_rep = pending_reports.pop_front();
                check_field("matched", exp_rep.matched, out_bus.matched);
                check_field("out_year", exp_rep.year, out_bus.out_year);
                check_field("out_month", exp_rep.month, out_bus.out_month);
                check_field("out_day", exp_rep.day, out_bus.out_day);
                check_field("out_hour", exp_rep.hour, out_bus.out_hour);
                check_field("out_minute", exp_rep.minute, out_bus.out_minute);
                check_field("out_weekday", exp_rep.weekday, out_bus.out_weekday);
            end
        end
    end

    initial begin
        out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_bus.ready <= !($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (cfg_bus.valid && cfg_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(t_minute_cmd c);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_bus.valid  <= 1'b1;
        in_bus.kind   <= c.kind;
        in_bus.year   <= c.year;
        in_bus.month  <= c.month;
        in_bus.day    <= c.day;
        in_bus.hour   <= c.hour;
        in_bus.minute <= c.minute;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        pending_reports.push_back(report_minute(c));
    endtask

    task automatic send_load(int y, int m, int d, int hh, int mm);
        t_minute_cmd c;
        c.kind   = KIND_LOAD;
        c.year   = YEAR_W'(y);
        c.month  = MONTH_W'(m);
        c.day    = DAY_W'(d);
        c.hour   = HOUR_W'(hh);
        c.minute = MINUTE_W'(mm);
        send_word(c);
    endtask

    // load fields are don't-care on a tick; keep them toggling
    task automatic send_tick();
        t_minute_cmd c;
        c.kind   = KIND_TICK;
        c.year   = YEAR_W'($urandom);
        c.month  = MONTH_W'($urandom);
        c.day    = DAY_W'($urandom);
        c.hour   = HOUR_W'($urandom);
        c.minute = MINUTE_W'($urandom);
        send_word(c);
    endtask

    task automatic drain_reports();
        in_bus.valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_word(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        apply_mask_write(idx, data);
    endtask

    // only called with nothing in flight
    task automatic program_masks(logic [CFG_DATA_W-1:0] mn, logic [CFG_DATA_W-1:0] hr,
                                 logic [CFG_DATA_W-1:0] dy, logic [CFG_DATA_W-1:0] mo,
                                 logic [CFG_DATA_W-1:0] wd, bit with_unused);
        cfg_word(CFG_MINUTE, mn);
        cfg_word(CFG_HOUR, hr);
        cfg_word(CFG_DAY, dy);
        cfg_word(CFG_MONTH, mo);
        cfg_word(CFG_WEEKDAY, wd);
        if (with_unused) begin
            cfg_word(CFG_IDX_W'(CFG_WEEKDAY) + CFG_IDX_W'($urandom_range(1, 3)),
                     CFG_DATA_W'({$urandom, $urandom}));
        end
        cfg_bus.valid <= 1'b0;
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_mask();
        logic [CFG_DATA_W-1:0] m;
        int                    mode;
        mode = $urandom_range(0, 19);
        m = '0;
        if (mode == 1) begin
            m = '1;
        end else if (mode == 2) begin
            m[$urandom_range(0, CFG_DATA_W - 1)] = 1'b1;
        end else if (mode != 0) begin
            for (int i = 0; i < CFG_DATA_W; i++) m[i] = ($urandom_range(0, 99) < 80);
        end
        return m;
    endfunction

    // a load, mostly near a rollover, followed by a run of ticks
    task automatic run_schedule(output int words);
        int y, m, d, hh, mm, sel, ticks;
        if ($urandom_range(0, 99) < 15) begin
            send_load($urandom_range(0, 16383), $urandom_range(0, 15),
                      $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 63));
        end else begin
            sel = $urandom_range(0, 5);
            case (sel)
                0:       y = $urandom_range(1, YEAR_MAX);
                1:       y = YEAR_MAX;
                2:       y = $urandom_range(1896, 2104);
                3:       y = 100 * $urandom_range(1, 99);
                4:       y = 400 * $urandom_range(1, 24);
                default: y = $urandom_range(1, 30);
            endcase
            m  = $urandom_range(1, 12);
            d  = $urandom_range(0, 1) ? month_days(y, m) - $urandom_range(0, 1)
                                      : $urandom_range(1, month_days(y, m));
            hh = $urandom_range(0, 1) ? 23 : $urandom_range(0, 23);
            mm = $urandom_range(0, 1) ? $urandom_range(50, 59) : $urandom_range(0, 59);
            if (sel == 1 && $urandom_range(0, 1)) begin
                m  = 12;
                d  = 31;
                hh = 23;
            end
            send_load(y, m, d, hh, mm);
        end
        ticks = $urandom_range(1, 25);
        repeat (ticks) send_tick();
        words = ticks + 1;
    endtask

    task automatic test_calendar_edges();
        send_tick();
        send_load(0, 0, 0, 0, 0);
        send_tick();
        send_load(16383, 15, 31, 31, 63);
        send_tick();
        send_tick();
        send_load(2024, 2, 31, 23, 59);
        send_tick();
        send_tick();
        send_load(2023, 2, 30, 23, 59);
        send_tick();
        send_tick();
        send_load(1900, 2, 29, 23, 59);
        send_tick();
        send_tick();
        send_load(2000, 2, 29, 23, 59);
        send_tick();
        send_tick();
        send_load(1999, 12, 31, 23, 59);
        send_tick();
        send_tick();
        send_load(2024, 4, 31, 23, 59);
        send_tick();
        send_tick();
        drain_reports();
    endtask

    // 2022-12-31 is a Saturday and 2023-01-01 a Sunday: lowest and highest
    // bit of every mask get hit on the way across the year boundary
    task automatic test_mask_extremes();
        logic [CFG_DATA_W-1:0] one;
        one = 1;
        send_idle_pct  = 36;
        recv_stall_pct = 36;
        for (int s = 0; s < 4; s++) begin
            case (s)
                0: program_masks('0, '0, '0, '0, '0, 1'b1);
                1: program_masks('1, '1, '1, '1, '1, 1'b1);
                2: program_masks(one, one, one, one, one, 1'b1);
                default: program_masks(one << 59, one << 23, one << 30, one << 11,
                                       one << 6, 1'b1);
            endcase
            send_load(2022, 12, 31, 23, 50);
            repeat (20) send_tick();
            drain_reports();
        end
    endtask

    task automatic test_random_schedules();
        int idle_set[4]  = '{0, 49, 0, 36};
        int stall_set[4] = '{0, 0, 49, 36};
        int sent, n;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_set[p];
            recv_stall_pct = stall_set[p];
            for (int b = 0; b < 3; b++) begin
                program_masks(random_mask(), random_mask(), random_mask(),
                              random_mask(), random_mask(), $urandom_range(0, 1));
                sent = 0;
                while (sent < BLOCK_WORDS) begin
                    run_schedule(n);
                    sent += n;
                end
                drain_reports();
            end
        end
    endtask

    initial begin
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        reset_calendar();
        i_rst_n       <= 1'b0;
        cfg_bus.valid <= 1'b0;
        cfg_bus.index <= CFG_MINUTE;
        cfg_bus.data  <= '0;
        in_bus.valid  <= 1'b0;
        in_bus.kind   <= KIND_TICK;
        in_bus.year   <= '0;
        in_bus.month  <= '0;
        in_bus.day    <= '0;
        in_bus.hour   <= '0;
        in_bus.minute <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_calendar_edges();
        test_mask_extremes();
        test_random_schedules();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/ccm_pkg.sv
sv/ccm_cfg_if.sv
sv/ccm_in_if.sv
sv/ccm_out_if.sv
sv/ccm_weekday.sv
sv/calendar_cron_minute_matcher.sv
tb/tb.sv
